/* rtl/core/sqb_pkg.sv */
// Shared constants, payload types and helpers for the stack and queue bank.
package sqb_pkg;

    localparam int NUM_STACKS = 16;
    localparam int NUM_QUEUES = 16;
    localparam int DEPTH      = 16;

    localparam int CMD_W    = 4;
    localparam int IDX_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 5;

    localparam int SIDX_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int SMEM_DEPTH = NUM_STACKS * DEPTH;
    localparam int QMEM_DEPTH = NUM_QUEUES * DEPTH;
    localparam int SADDR_W    = $clog2(SMEM_DEPTH);
    localparam int QADDR_W    = $clog2(QMEM_DEPTH);

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLR_STACK = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_S2S       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PRN_STACK = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CLR_QUEUE = 4'd5;
    localparam logic [CMD_W-1:0] CMD_ENQ       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DEQ       = 4'd7;
    localparam logic [CMD_W-1:0] CMD_PRN_QUEUE = 4'd8;
    localparam logic [CMD_W-1:0] CMD_S2Q       = 4'd9;
    localparam logic [CMD_W-1:0] CMD_Q2Q       = 4'd10;
    localparam logic [CMD_W-1:0] CMD_Q2S       = 4'd11;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SFULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SEMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QFULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QEMPTY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_PEMPTY  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_ELEM    = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] operand;
    } t_cmd_item;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_result;

    // (base + off) mod DEPTH, both operands below DEPTH
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

    function automatic logic [SADDR_W-1:0] s_addr(input logic [SIDX_W-1:0] idx,
                                                  input logic [SLOT_W-1:0] slot);
        return SADDR_W'(int'(idx) * DEPTH + int'(slot));
    endfunction

    function automatic logic [QADDR_W-1:0] q_addr(input logic [QIDX_W-1:0] idx,
                                                  input logic [SLOT_W-1:0] slot);
        return QADDR_W'(int'(idx) * DEPTH + int'(slot));
    endfunction

endpackage

/* rtl/core/sqb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sqb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/stack_and_queue_bank_core.sv */
// Top level of the stack and queue bank: command sequencer, counters and word stores.
// Usage
//   Command channel (i_in_valid / o_in_ready / i_in_data) takes one request at a time;
//   ready is high only while the sequencer is idle. Result channel (o_out_valid /
//   i_out_ready / o_out_data) presents results from an output register; last marks the
//   final result of a request. Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data)
//   writes the capacity register and is always ready; write it only while idle.
// Timing
//   Each request first looks up the counters of its source (S_SRC) and destination
//   (S_DST), then executes in S_EXEC. A simple request shows its result from S_DONE; the
//   input is ready again as the result appears, not before. Transfers add a store read
//   and a write (S_MOVE, S_PUT). A print walks the store element by element, reading
//   each (S_PRD) and then emitting it (S_PEMIT). The single read port of each word store
//   and the one shared counter read port set this sequence.
// Reset
//   Synchronous, active low: all stacks and queues become empty, capacity returns to 10,
//   no result is pending. The word stores are not cleared.
// Back-pressure
//   When the result register is full and not taken, the sequencer waits in place; a
//   new request is accepted as soon as the current one has handed over its last result.
module stack_and_queue_bank_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sqb_pkg::t_cmd_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output sqb_pkg::t_result               o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sqb_pkg::CAP_W-1:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRC, S_DST, S_EXEC, S_MOVE, S_PUT, S_PRD, S_PEMIT, S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [sqb_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [sqb_pkg::IDX_W-1:0]    r_a, n_a;
    logic [sqb_pkg::DATA_W-1:0]   r_operand, n_operand;
    logic [sqb_pkg::CAP_W-1:0]    r_cap;
    logic [sqb_pkg::CNT_W-1:0]    r_cnt_as, n_cnt_as, r_cnt_aq, n_cnt_aq;
    logic [sqb_pkg::CNT_W-1:0]    r_cnt_bs, n_cnt_bs, r_cnt_bq, n_cnt_bq;
    logic [sqb_pkg::SLOT_W-1:0]   r_head_a, n_head_a;
    logic [sqb_pkg::STATUS_W-1:0] r_status, n_status;
    logic [sqb_pkg::DATA_W-1:0]   r_data, n_data;
    logic                         r_src_q, n_src_q, r_dst_q, n_dst_q;
    logic [sqb_pkg::CNT_W-1:0]    r_i, n_i, r_n, n_n;
    logic                         r_out_valid, n_out_valid;
    sqb_pkg::t_result             r_out, n_out;

    logic [sqb_pkg::CNT_W-1:0]    r_stack_cnt [sqb_pkg::NUM_STACKS];
    logic [sqb_pkg::CNT_W-1:0]    r_queue_cnt [sqb_pkg::NUM_QUEUES];
    logic [sqb_pkg::SLOT_W-1:0]   r_queue_head [sqb_pkg::NUM_QUEUES];

    // counter write ports
    logic                         s_cnt_we;
    logic [sqb_pkg::SIDX_W-1:0]   s_cnt_wa;
    logic [sqb_pkg::CNT_W-1:0]    s_cnt_wd;
    logic                         q_cnt_we;
    logic [sqb_pkg::QIDX_W-1:0]   q_cnt_wa;
    logic [sqb_pkg::CNT_W-1:0]    q_cnt_wd;
    logic [sqb_pkg::SLOT_W-1:0]   q_head_wd;

    // word store ports
    logic                         s_we, s_re, q_we, q_re;
    logic [sqb_pkg::SADDR_W-1:0]  s_waddr, s_raddr;
    logic [sqb_pkg::QADDR_W-1:0]  q_waddr, q_raddr;
    logic [sqb_pkg::DATA_W-1:0]   s_wdata, q_wdata, s_rdata, q_rdata, w_rdata;

    logic [sqb_pkg::IDX_W-1:0]    w_b, w_sel;
    logic [sqb_pkg::CNT_W-1:0]    w_s_cnt, w_q_cnt, w_cap;
    logic [sqb_pkg::SLOT_W-1:0]   w_q_head;
    logic                         oka_s, oka_q, okb_s, okb_q;
    logic                         sfull_a, sempty_a, qfull_a, qempty_a;
    logic                         sfull_b, qfull_b;
    logic                         out_free, out_load;
    logic [sqb_pkg::SIDX_W-1:0]   sa, sb;
    logic [sqb_pkg::QIDX_W-1:0]   qa, qb;

    assign w_b   = r_operand[sqb_pkg::IDX_W-1:0];
    assign w_sel = (r_state == S_DST || r_state == S_PUT) ? w_b : r_a;
    assign sa    = sqb_pkg::SIDX_W'(r_a);
    assign sb    = sqb_pkg::SIDX_W'(w_b);
    assign qa    = sqb_pkg::QIDX_W'(r_a);
    assign qb    = sqb_pkg::QIDX_W'(w_b);

    // one shared counter read port
    assign w_s_cnt  = r_stack_cnt[sqb_pkg::SIDX_W'(w_sel)];
    assign w_q_cnt  = r_queue_cnt[sqb_pkg::QIDX_W'(w_sel)];
    assign w_q_head = r_queue_head[sqb_pkg::QIDX_W'(w_sel)];

    assign w_cap = (int'(r_cap) > sqb_pkg::DEPTH) ? sqb_pkg::CNT_W'(sqb_pkg::DEPTH)
                                                   : sqb_pkg::CNT_W'(r_cap);

    assign oka_s = int'(r_a) < sqb_pkg::NUM_STACKS;
    assign oka_q = int'(r_a) < sqb_pkg::NUM_QUEUES;
    assign okb_s = int'(w_b) < sqb_pkg::NUM_STACKS;
    assign okb_q = int'(w_b) < sqb_pkg::NUM_QUEUES;

    assign sempty_a = !oka_s || (r_cnt_as == '0);
    assign qempty_a = !oka_q || (r_cnt_aq == '0);
    assign sfull_a  = !oka_s || (r_cnt_as >= w_cap);
    assign qfull_a  = !oka_q || (r_cnt_aq >= w_cap);
    assign sfull_b  = !okb_s || (r_cnt_bs >= w_cap);
    assign qfull_b  = !okb_q || (r_cnt_bq >= w_cap);

    assign out_free = !r_out_valid || i_out_ready;
    assign w_rdata  = r_src_q ? q_rdata : s_rdata;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_a         = r_a;
        n_operand   = r_operand;
        n_cnt_as    = r_cnt_as;
        n_cnt_aq    = r_cnt_aq;
        n_cnt_bs    = r_cnt_bs;
        n_cnt_bq    = r_cnt_bq;
        n_head_a    = r_head_a;
        n_status    = r_status;
        n_data      = r_data;
        n_src_q     = r_src_q;
        n_dst_q     = r_dst_q;
        n_i         = r_i;
        n_n         = r_n;
        n_out       = r_out;
        out_load    = 1'b0;

        s_cnt_we  = 1'b0;
        s_cnt_wa  = sa;
        s_cnt_wd  = '0;
        q_cnt_we  = 1'b0;
        q_cnt_wa  = qa;
        q_cnt_wd  = '0;
        q_head_wd = '0;

        s_we    = 1'b0;
        s_re    = 1'b0;
        s_waddr = '0;
        s_raddr = '0;
        s_wdata = r_operand;
        q_we    = 1'b0;
        q_re    = 1'b0;
        q_waddr = '0;
        q_raddr = '0;
        q_wdata = r_operand;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_in_data.command;
                    n_a       = i_in_data.index;
                    n_operand = i_in_data.operand;
                    n_state   = S_SRC;
                end
            end
            S_SRC: begin
                n_cnt_as = w_s_cnt;
                n_cnt_aq = w_q_cnt;
                n_head_a = w_q_head;
                n_state  = S_DST;
            end
            S_DST: begin
                n_cnt_bs = w_s_cnt;
                n_cnt_bq = w_q_cnt;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_status = sqb_pkg::ST_DONE;
                n_state  = S_DONE;
                unique case (r_cmd) inside
                    sqb_pkg::CMD_CLR_STACK: begin
                        s_cnt_we = oka_s;
                    end
                    sqb_pkg::CMD_PUSH: begin
                        if (sfull_a) begin
                            n_status = sqb_pkg::ST_SFULL;
                        end else begin
                            s_we     = 1'b1;
                            s_waddr  = sqb_pkg::s_addr(sa, sqb_pkg::SLOT_W'(r_cnt_as));
                            s_cnt_we = 1'b1;
                            s_cnt_wd = r_cnt_as + 1'b1;
                        end
                    end
                    sqb_pkg::CMD_POP: begin
                        if (sempty_a) begin
                            n_status = sqb_pkg::ST_SEMPTY;
                        end else begin
                            s_cnt_we = 1'b1;
                            s_cnt_wd = r_cnt_as - 1'b1;
                        end
                    end
                    sqb_pkg::CMD_CLR_QUEUE: begin
                        q_cnt_we = oka_q;
                    end
                    sqb_pkg::CMD_ENQ: begin
                        if (qfull_a) begin
                            n_status = sqb_pkg::ST_QFULL;
                        end else begin
                            q_we      = 1'b1;
                            q_waddr   = sqb_pkg::q_addr(qa,
                                            sqb_pkg::slot_add(r_head_a, r_cnt_aq));
                            q_cnt_we  = 1'b1;
                            q_cnt_wd  = r_cnt_aq + 1'b1;
                            q_head_wd = r_head_a;
                        end
                    end
                    sqb_pkg::CMD_DEQ: begin
                        if (qempty_a) begin
                            n_status = sqb_pkg::ST_QEMPTY;
                        end else begin
                            q_cnt_we  = 1'b1;
                            q_cnt_wd  = r_cnt_aq - 1'b1;
                            q_head_wd = sqb_pkg::slot_add(r_head_a, sqb_pkg::CNT_W'(1));
                        end
                    end
                    sqb_pkg::CMD_PRN_STACK: begin
                        if (sempty_a) begin
                            n_status = sqb_pkg::ST_PEMPTY;
                        end else begin
                            n_src_q = 1'b0;
                            n_i     = '0;
                            n_n     = r_cnt_as;
                            n_state = S_PRD;
                        end
                    end
                    sqb_pkg::CMD_PRN_QUEUE: begin
                        if (qempty_a) begin
                            n_status = sqb_pkg::ST_PEMPTY;
                        end else begin
                            n_src_q = 1'b1;
                            n_i     = '0;
                            n_n     = r_cnt_aq;
                            n_state = S_PRD;
                        end
                    end
                    sqb_pkg::CMD_S2S, sqb_pkg::CMD_S2Q: begin
                        if (sempty_a || (r_cmd == sqb_pkg::CMD_S2S ? sfull_b : qfull_b)) begin
                            n_status = sqb_pkg::ST_REFUSED;
                        end else begin
                            s_re    = 1'b1;
                            s_raddr = sqb_pkg::s_addr(sa,
                                          sqb_pkg::SLOT_W'(r_cnt_as - 1'b1));
                            n_src_q = 1'b0;
                            n_dst_q = (r_cmd == sqb_pkg::CMD_S2Q);
                            n_state = S_MOVE;
                        end
                    end
                    sqb_pkg::CMD_Q2Q, sqb_pkg::CMD_Q2S: begin
                        if (qempty_a || (r_cmd == sqb_pkg::CMD_Q2Q ? qfull_b : sfull_b)) begin
                            n_status = sqb_pkg::ST_REFUSED;
                        end else begin
                            q_re    = 1'b1;
                            q_raddr = sqb_pkg::q_addr(qa, r_head_a);
                            n_src_q = 1'b1;
                            n_dst_q = (r_cmd == sqb_pkg::CMD_Q2Q);
                            n_state = S_MOVE;
                        end
                    end
                    default: begin
                        n_status = sqb_pkg::ST_DONE;
                    end
                endcase
            end
            S_MOVE: begin
                // source word is on the read port now; take it out of the source
                n_data = w_rdata;
                if (r_src_q) begin
                    q_cnt_we  = 1'b1;
                    q_cnt_wd  = r_cnt_aq - 1'b1;
                    q_head_wd = sqb_pkg::slot_add(r_head_a, sqb_pkg::CNT_W'(1));
                end else begin
                    s_cnt_we = 1'b1;
                    s_cnt_wd = r_cnt_as - 1'b1;
                end
                n_state = S_PUT;
            end
            S_PUT: begin
                // destination counters read live, so a self transfer sees the removal
                if (r_dst_q) begin
                    q_we      = 1'b1;
                    q_wdata   = r_data;
                    q_waddr   = sqb_pkg::q_addr(qb, sqb_pkg::slot_add(w_q_head, w_q_cnt));
                    q_cnt_we  = 1'b1;
                    q_cnt_wa  = qb;
                    q_cnt_wd  = w_q_cnt + 1'b1;
                    q_head_wd = w_q_head;
                end else begin
                    s_we     = 1'b1;
                    s_wdata  = r_data;
                    s_waddr  = sqb_pkg::s_addr(sb, sqb_pkg::SLOT_W'(w_s_cnt));
                    s_cnt_we = 1'b1;
                    s_cnt_wa = sb;
                    s_cnt_wd = w_s_cnt + 1'b1;
                end
                n_status = sqb_pkg::ST_DONE;
                n_state  = S_DONE;
            end
            S_PRD: begin
                // stack bottom to top, queue newest to oldest
                if (r_src_q) begin
                    q_re    = 1'b1;
                    q_raddr = sqb_pkg::q_addr(qa,
                                  sqb_pkg::slot_add(r_head_a, r_n - 1'b1 - r_i));
                end else begin
                    s_re    = 1'b1;
                    s_raddr = sqb_pkg::s_addr(sa, sqb_pkg::SLOT_W'(r_i));
                end
                n_state = S_PEMIT;
            end
            S_PEMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out.status = sqb_pkg::ST_ELEM;
                    n_out.value  = w_rdata;
                    n_out.last   = (r_i == r_n - 1'b1);
                    if (r_i == r_n - 1'b1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_PRD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out.status = r_status;
                    n_out.value  = '0;
                    n_out.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cap       <= sqb_pkg::CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
        r_cmd     <= n_cmd;
        r_a       <= n_a;
        r_operand <= n_operand;
        r_cnt_as  <= n_cnt_as;
        r_cnt_aq  <= n_cnt_aq;
        r_cnt_bs  <= n_cnt_bs;
        r_cnt_bq  <= n_cnt_bq;
        r_head_a  <= n_head_a;
        r_status  <= n_status;
        r_data    <= n_data;
        r_src_q   <= n_src_q;
        r_dst_q   <= n_dst_q;
        r_i       <= n_i;
        r_n       <= n_n;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sqb_pkg::NUM_STACKS; k++) begin
                r_stack_cnt[k] <= '0;
            end
            for (int k = 0; k < sqb_pkg::NUM_QUEUES; k++) begin
                r_queue_cnt[k]  <= '0;
                r_queue_head[k] <= '0;
            end
        end else begin
            if (s_cnt_we) begin
                r_stack_cnt[s_cnt_wa] <= s_cnt_wd;
            end
            if (q_cnt_we) begin
                r_queue_cnt[q_cnt_wa]  <= q_cnt_wd;
                r_queue_head[q_cnt_wa] <= q_head_wd;
            end
        end
    end

    sqb_ram #(
        .WIDTH (sqb_pkg::DATA_W),
        .DEPTH (sqb_pkg::SMEM_DEPTH)
    ) u_stack_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    sqb_ram #(
        .WIDTH (sqb_pkg::DATA_W),
        .DEPTH (sqb_pkg::QMEM_DEPTH)
    ) u_queue_store (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // a push never takes a stack past the capacity
    a_push_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cnt_we && r_state == S_EXEC && r_cmd == sqb_pkg::CMD_PUSH) |-> s_cnt_wd <= w_cap)
        else $error("push beyond capacity");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while busy");

    // the final result of a request frees the sequencer
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.last) |=> (r_state == S_IDLE))
        else $error("last result without return to idle");

    // element results only come from a print walk
    a_elem_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.status == sqb_pkg::ST_ELEM) |->
            (r_cmd == sqb_pkg::CMD_PRN_STACK || r_cmd == sqb_pkg::CMD_PRN_QUEUE))
        else $error("element result outside print");

endmodule

/* dv/tb_top.sv */
// Self-checking bench for the stack and queue bank: directed table, random requests, back-pressure.
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES = 200;   // long result back-pressure
    localparam int SETTLE      = 4;     // idle gap after the last result; the input is already free when it appears
    localparam int TAIL        = 20;

    // unnamed command codes, no effect
    localparam logic [sqb_pkg::CMD_W-1:0] CMD_NOP_LO = 4'd12;
    localparam logic [sqb_pkg::CMD_W-1:0] CMD_NOP_HI = 4'd15;

    typedef struct {
        sqb_pkg::t_cmd_item req;
        bit                 typed;
        sqb_pkg::t_result   want;
    } t_row;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cmd_valid = 1'b0;
    logic                       cmd_ready;
    sqb_pkg::t_cmd_item         cmd_data  = '0;
    logic                       res_valid;
    logic                       res_ready = 1'b0;
    sqb_pkg::t_result           res_data;
    logic                       cap_valid = 1'b0;
    logic                       cap_ready;
    logic [sqb_pkg::CAP_W-1:0]  cap_data  = '0;

    // shadow state of the bank
    logic [sqb_pkg::DATA_W-1:0] stk_mem  [sqb_pkg::NUM_STACKS][sqb_pkg::DEPTH];
    logic [sqb_pkg::CNT_W-1:0]  stk_cnt  [sqb_pkg::NUM_STACKS];
    logic [sqb_pkg::DATA_W-1:0] que_mem  [sqb_pkg::NUM_QUEUES][sqb_pkg::DEPTH];
    logic [sqb_pkg::SLOT_W-1:0] que_head [sqb_pkg::NUM_QUEUES];
    logic [sqb_pkg::CNT_W-1:0]  que_cnt  [sqb_pkg::NUM_QUEUES];
    logic [sqb_pkg::CAP_W-1:0]  cap_reg;

    sqb_pkg::t_result step_out[$];
    sqb_pkg::t_result due_results[$];
    t_row             dir_tab[$];

    int err_cnt      = 0;
    int stall_cycles = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    bit calm         = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stack_and_queue_bank_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (cmd_valid),
        .o_in_ready (cmd_ready),
        .i_in_data  (cmd_data),
        .o_out_valid(res_valid),
        .i_out_ready(res_ready),
        .o_out_data (res_data),
        .i_cfg_valid(cap_valid),
        .o_cfg_ready(cap_ready),
        .i_cfg_data (cap_data)
    );

    // ---------------- list helpers ----------------

    function automatic void add_row(input t_row r);
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    function automatic void book_result(input sqb_pkg::t_result r);
        due_results.insert(due_results.size(), r);
    endfunction

    // ---------------- shadow model ----------------

    function automatic int cap_limit();
        return (int'(cap_reg) > sqb_pkg::DEPTH) ? sqb_pkg::DEPTH : int'(cap_reg);
    endfunction

    function automatic bit stk_empty(input int i);
        return i >= sqb_pkg::NUM_STACKS || stk_cnt[i] == 0;
    endfunction

    function automatic bit stk_full(input int i);
        return i >= sqb_pkg::NUM_STACKS || int'(stk_cnt[i]) >= cap_limit();
    endfunction

    function automatic bit que_empty(input int i);
        return i >= sqb_pkg::NUM_QUEUES || que_cnt[i] == 0;
    endfunction

    function automatic bit que_full(input int i);
        return i >= sqb_pkg::NUM_QUEUES || int'(que_cnt[i]) >= cap_limit();
    endfunction

    function automatic void stk_put(input int i, input logic [sqb_pkg::DATA_W-1:0] v);
        stk_mem[i][stk_cnt[i]] = v;
        stk_cnt[i] = stk_cnt[i] + 1'b1;
    endfunction

    function automatic logic [sqb_pkg::DATA_W-1:0] stk_take(input int i);
        stk_cnt[i] = stk_cnt[i] - 1'b1;
        return stk_mem[i][stk_cnt[i]];
    endfunction

    function automatic void que_put(input int i, input logic [sqb_pkg::DATA_W-1:0] v);
        int slot;
        slot = (int'(que_head[i]) + int'(que_cnt[i])) % sqb_pkg::DEPTH;
        que_mem[i][slot] = v;
        que_cnt[i] = que_cnt[i] + 1'b1;
    endfunction

    function automatic logic [sqb_pkg::DATA_W-1:0] que_take(input int i);
        logic [sqb_pkg::DATA_W-1:0] v;
        v = que_mem[i][que_head[i]];
        que_head[i] = sqb_pkg::SLOT_W'((int'(que_head[i]) + 1) % sqb_pkg::DEPTH);
        que_cnt[i] = que_cnt[i] - 1'b1;
        return v;
    endfunction

    function automatic void emit(input logic [sqb_pkg::STATUS_W-1:0] st,
                                 input logic [sqb_pkg::DATA_W-1:0] v,
                                 input logic lst);
        sqb_pkg::t_result r;
        r.status = st;
        r.value  = v;
        r.last   = lst;
        step_out.insert(step_out.size(), r);
    endfunction

    // Updates the shadow state for one request and leaves its results in step_out.
    function automatic void apply_request(input sqb_pkg::t_cmd_item req);
        int src, dst, n;
        logic [sqb_pkg::STATUS_W-1:0] st;
        src = int'(req.index);
        dst = int'(req.operand[3:0]);
        st  = sqb_pkg::ST_DONE;
        step_out.delete();
        case (req.command)
            sqb_pkg::CMD_CLR_STACK: if (src < sqb_pkg::NUM_STACKS) stk_cnt[src] = '0;
            sqb_pkg::CMD_PUSH: begin
                if (stk_full(src)) st = sqb_pkg::ST_SFULL;
                else stk_put(src, req.operand);
            end
            sqb_pkg::CMD_POP: begin
                if (stk_empty(src)) st = sqb_pkg::ST_SEMPTY;
                else void'(stk_take(src));
            end
            sqb_pkg::CMD_S2S: begin
                if (stk_empty(src) || stk_full(dst)) st = sqb_pkg::ST_REFUSED;
                else stk_put(dst, stk_take(src));
            end
            sqb_pkg::CMD_PRN_STACK: begin
                if (stk_empty(src)) begin
                    st = sqb_pkg::ST_PEMPTY;
                end else begin
                    n = int'(stk_cnt[src]);
                    for (int k = 0; k < n; k++)
                        emit(sqb_pkg::ST_ELEM, stk_mem[src][k], k == n - 1);
                    return;
                end
            end
            sqb_pkg::CMD_CLR_QUEUE: begin
                if (src < sqb_pkg::NUM_QUEUES) begin
                    que_cnt[src]  = '0;
                    que_head[src] = '0;
                end
            end
            sqb_pkg::CMD_ENQ: begin
                if (que_full(src)) st = sqb_pkg::ST_QFULL;
                else que_put(src, req.operand);
            end
            sqb_pkg::CMD_DEQ: begin
                if (que_empty(src)) st = sqb_pkg::ST_QEMPTY;
                else void'(que_take(src));
            end
            sqb_pkg::CMD_PRN_QUEUE: begin
                if (que_empty(src)) begin
                    st = sqb_pkg::ST_PEMPTY;
                end else begin
                    // newest first
                    n = int'(que_cnt[src]);
                    for (int k = 0; k < n; k++)
                        emit(sqb_pkg::ST_ELEM,
                             que_mem[src][(int'(que_head[src]) + n - 1 - k) % sqb_pkg::DEPTH],
                             k == n - 1);
                    return;
                end
            end
            sqb_pkg::CMD_S2Q: begin
                if (stk_empty(src) || que_full(dst)) st = sqb_pkg::ST_REFUSED;
                else que_put(dst, stk_take(src));
            end
            sqb_pkg::CMD_Q2Q: begin
                if (que_empty(src) || que_full(dst)) st = sqb_pkg::ST_REFUSED;
                else que_put(dst, que_take(src));
            end
            sqb_pkg::CMD_Q2S: begin
                if (que_empty(src) || stk_full(dst)) st = sqb_pkg::ST_REFUSED;
                else stk_put(dst, que_take(src));
            end
            default: ;
        endcase
        emit(st, '0, 1'b1);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_row mk(input logic [sqb_pkg::CMD_W-1:0] c,
                                input logic [sqb_pkg::IDX_W-1:0] i,
                                input logic [sqb_pkg::DATA_W-1:0] op);
        t_row r;
        r.req.command = c;
        r.req.index   = i;
        r.req.operand = op;
        r.typed       = 1'b0;
        r.want        = '0;
        return r;
    endfunction

    function automatic t_row mk_t(input logic [sqb_pkg::CMD_W-1:0] c,
                                  input logic [sqb_pkg::IDX_W-1:0] i,
                                  input logic [sqb_pkg::DATA_W-1:0] op,
                                  input logic [sqb_pkg::STATUS_W-1:0] st);
        t_row r;
        r = mk(c, i, op);
        r.typed       = 1'b1;
        r.want.status = st;
        r.want.last   = 1'b1;
        return r;
    endfunction

    function automatic logic [sqb_pkg::IDX_W-1:0] pick_idx(input int span);
        if ($urandom_range(0, 9) == 0) return sqb_pkg::IDX_W'($urandom_range(0, 15));
        return sqb_pkg::IDX_W'($urandom_range(0, span));
    endfunction

    function automatic sqb_pkg::t_cmd_item rand_req(input int span, input int ins_pct);
        sqb_pkg::t_cmd_item r;
        int roll;
        r.index   = pick_idx(span);
        r.operand = $urandom;
        roll      = $urandom_range(0, 99);
        if (roll >= 97) begin
            r.command = CMD_NOP_LO
                      + sqb_pkg::CMD_W'($urandom_range(0, CMD_NOP_HI - CMD_NOP_LO));
        end else if (roll < ins_pct) begin
            r.command = $urandom_range(0, 1) ? sqb_pkg::CMD_PUSH : sqb_pkg::CMD_ENQ;
        end else begin
            case ($urandom_range(0, 11))
                0, 1:    r.command = sqb_pkg::CMD_POP;
                2, 3:    r.command = sqb_pkg::CMD_DEQ;
                4:       r.command = sqb_pkg::CMD_S2S;
                5:       r.command = sqb_pkg::CMD_S2Q;
                6:       r.command = sqb_pkg::CMD_Q2Q;
                7:       r.command = sqb_pkg::CMD_Q2S;
                8:       r.command = sqb_pkg::CMD_PRN_STACK;
                9:       r.command = sqb_pkg::CMD_PRN_QUEUE;
                10:      r.command = sqb_pkg::CMD_CLR_STACK;
                default: r.command = sqb_pkg::CMD_CLR_QUEUE;
            endcase
            if (r.command inside {sqb_pkg::CMD_S2S, sqb_pkg::CMD_S2Q,
                                  sqb_pkg::CMD_Q2Q, sqb_pkg::CMD_Q2S})
                r.operand[3:0] = pick_idx(span);
        end
        return r;
    endfunction

    // Offers one request, holds it until taken, then books its results.
    task automatic send_req(input sqb_pkg::t_cmd_item req, input bit typed,
                            input sqb_pkg::t_result want);
        if (!calm && $urandom_range(0, 5) == 0) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= req;
        do @(posedge clk); while (!cmd_ready);
        apply_request(req);
        if (typed) begin
            book_result(want);
        end else begin
            foreach (step_out[k]) book_result(step_out[k]);
        end
    endtask

    task automatic random_run(input int n, input int span, input int ins_pct);
        for (int k = 0; k < n; k++) send_req(rand_req(span, ins_pct), 1'b0, '0);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [sqb_pkg::CAP_W-1:0] v);
        cap_valid <= 1'b1;
        cap_data  <= v;
        do @(posedge clk); while (!cap_ready);
        cap_valid <= 1'b0;
        cap_reg = v;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // ---------------- result side ----------------

    initial begin
        wait (rst_n);
        forever begin
            if (hold_served != hold_asked) begin
                hold_served++;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        sqb_pkg::t_result want;
        if (rst_n && res_valid && res_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, status", res_data.status, -1);
            end else begin
                want = due_results.pop_front();
                if (res_data.status !== want.status)
                    report_mismatch("status", res_data.status, want.status);
                if (res_data.value !== want.value)
                    report_mismatch("value", res_data.value, want.value);
                if (res_data.last !== want.last)
                    report_mismatch("last", res_data.last, want.last);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)
                || (cap_valid && cap_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles < STALL_LIMIT) begin
            stall_cycles <= stall_cycles + 1;
        end else begin
            $display("FAIL stack_and_queue_bank_core");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int split;
        foreach (stk_cnt[k]) stk_cnt[k] = '0;
        foreach (que_cnt[k]) begin
            que_cnt[k]  = '0;
            que_head[k] = '0;
        end
        cap_reg = sqb_pkg::CAP_RESET;

        // capacity at its reset value
        add_row(mk_t(sqb_pkg::CMD_POP,       0,  '0,            sqb_pkg::ST_SEMPTY));
        add_row(mk_t(sqb_pkg::CMD_DEQ,       0,  '0,            sqb_pkg::ST_QEMPTY));
        add_row(mk_t(sqb_pkg::CMD_PRN_STACK, 0,  '0,            sqb_pkg::ST_PEMPTY));
        add_row(mk_t(sqb_pkg::CMD_PRN_QUEUE, 15, '0,            sqb_pkg::ST_PEMPTY));
        add_row(mk_t(sqb_pkg::CMD_S2S,       0,  32'h1,         sqb_pkg::ST_REFUSED));
        add_row(mk_t(sqb_pkg::CMD_Q2S,       3,  32'hFFFF_FFF0, sqb_pkg::ST_REFUSED));
        add_row(mk_t(sqb_pkg::CMD_PUSH,      0,  32'h7FFF_FFFF, sqb_pkg::ST_DONE));
        add_row(mk_t(sqb_pkg::CMD_PUSH,      0,  32'h8000_0000, sqb_pkg::ST_DONE));
        add_row(mk  (sqb_pkg::CMD_PUSH,      0,  32'hFFFF_FFFF));
        add_row(mk  (sqb_pkg::CMD_PRN_STACK, 0,  '0));
        add_row(mk_t(sqb_pkg::CMD_ENQ,       15, 32'h8000_0000, sqb_pkg::ST_DONE));
        add_row(mk_t(sqb_pkg::CMD_ENQ,       15, 32'h7FFF_FFFF, sqb_pkg::ST_DONE));
        add_row(mk  (sqb_pkg::CMD_ENQ,       15, 32'h0000_5A5A));
        add_row(mk  (sqb_pkg::CMD_PRN_QUEUE, 15, '0));
        // upper operand bits of a transfer are don't-care
        add_row(mk  (sqb_pkg::CMD_S2S,       0,  32'hFFFF_FFF5));
        add_row(mk  (sqb_pkg::CMD_S2S,       0,  32'h0));
        add_row(mk  (sqb_pkg::CMD_S2Q,       0,  32'h0000_000F));
        add_row(mk  (sqb_pkg::CMD_Q2Q,       15, 32'h1234_567F));
        add_row(mk  (sqb_pkg::CMD_Q2Q,       15, 32'h2));
        add_row(mk  (sqb_pkg::CMD_Q2S,       15, 32'hAAAA_AAAF));
        add_row(mk_t(CMD_NOP_LO,             7,  32'hFFFF_FFFF, sqb_pkg::ST_DONE));
        add_row(mk_t(CMD_NOP_HI,             15, '0,            sqb_pkg::ST_DONE));
        add_row(mk  (sqb_pkg::CMD_PRN_QUEUE, 15, '0));
        add_row(mk  (sqb_pkg::CMD_PRN_STACK, 15, '0));
        add_row(mk_t(sqb_pkg::CMD_CLR_STACK, 0,  '0,            sqb_pkg::ST_DONE));
        add_row(mk_t(sqb_pkg::CMD_CLR_QUEUE, 15, '0,            sqb_pkg::ST_DONE));
        add_row(mk_t(sqb_pkg::CMD_POP,       0,  '0,            sqb_pkg::ST_SEMPTY));
        // capacity zero from here: stack 5 and queue 2 sit above it
        split = dir_tab.size();
        add_row(mk_t(sqb_pkg::CMD_PUSH,      1,  32'h1,         sqb_pkg::ST_SFULL));
        add_row(mk_t(sqb_pkg::CMD_ENQ,       1,  32'h1,         sqb_pkg::ST_QFULL));
        add_row(mk_t(sqb_pkg::CMD_S2S,       5,  32'h6,         sqb_pkg::ST_REFUSED));
        add_row(mk_t(sqb_pkg::CMD_Q2Q,       2,  32'h3,         sqb_pkg::ST_REFUSED));
        add_row(mk_t(sqb_pkg::CMD_POP,       5,  '0,            sqb_pkg::ST_DONE));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k]) begin
            if (k == split) begin
                drain();
                write_capacity('0);
            end
            send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);
        end

        // above depth: fill one stack and one queue, then churn so the queue wraps
        drain();
        write_capacity(5'd31);
        random_run(40, 0, 85);
        random_run(30, 1, 45);

        // capacity dropped under the counts; results held off while the next request waits
        drain();
        write_capacity(5'd3);
        hold_asked++;
        random_run(15, 1, 45);
        drain();
        random_run(15, 1, 45);

        drain();
        write_capacity(5'd1);
        random_run(15, 2, 50);

        drain();
        write_capacity(5'd16);
        random_run(10, 3, 50);

        drain();
        write_capacity(sqb_pkg::CAP_W'($urandom_range(0, 31)));
        calm = 1'b1;
        random_run(15, 3, 50);

        drain();
        repeat (TAIL) @(posedge clk);
        if (err_cnt == 0) begin
            $display("PASS stack_and_queue_bank_core");
        end else begin
            $display("FAIL stack_and_queue_bank_core");
        end
        $finish;
    end

endmodule

/* stack_and_queue_bank_core.f */
rtl/core/sqb_pkg.sv
rtl/core/sqb_ram.sv
rtl/core/stack_and_queue_bank_core.sv
dv/tb_top.sv
